// ===== hdl/pcdc_pkg.sv =====
// ---------------------------------------------------------------------------
// pcdc_pkg: shared widths, register indexes and reset values
// Constants used by the pointer clamp and double click tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pcdc_pkg;

  localparam int unsigned PosW    = 12;  // pointer coordinate
  localparam int unsigned BoundW  = 13;  // exclusive upper bound
  localparam int unsigned DeltaW  = 10;  // signed movement
  localparam int unsigned SumW    = 14;  // signed position plus delta
  localparam int unsigned BtnW    = 4;   // button bits
  localparam int unsigned StateW  = 5;   // buttons plus double click flag
  localparam int unsigned TimeW   = 32;  // millisecond time stamp
  localparam int unsigned WinW    = 16;  // click window
  localparam int unsigned LimW    = 9;   // move limit
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned InDataW  = 56;  // 4 + 10 + 10 + 32, whole bytes
  localparam int unsigned OutDataW = 32;  // 12 + 12 + 5, padded to bytes

  // Largest coordinate on either axis.
  localparam logic [PosW-1:0]   PosMax   = {PosW{1'b1}};
  localparam logic [BoundW-1:0] BoundTop = BoundW'(1 << PosW);

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegLeft   = 3'd0;
  localparam logic [CfgAddrW-1:0] RegTop    = 3'd1;
  localparam logic [CfgAddrW-1:0] RegRight  = 3'd2;
  localparam logic [CfgAddrW-1:0] RegBottom = 3'd3;
  localparam logic [CfgAddrW-1:0] RegWindow = 3'd4;
  localparam logic [CfgAddrW-1:0] RegMove   = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [PosW-1:0]   LeftRst   = '0;
  localparam logic [PosW-1:0]   TopRst    = '0;
  localparam logic [BoundW-1:0] RightRst  = 13'd640;
  localparam logic [BoundW-1:0] BottomRst = 13'd480;
  localparam logic [WinW-1:0]   WindowRst = 16'd400;
  localparam logic [LimW-1:0]   MoveRst   = 9'd10;

endpackage : pcdc_pkg

`default_nettype wire

// ===== hdl/pcdc_clamp.sv =====
// ---------------------------------------------------------------------------
// pcdc_clamp: one axis of the pointer position update
// Add a signed delta to the position and clamp to [lo, hi_excl - 1].
// ---------------------------------------------------------------------------
`default_nettype none

module pcdc_clamp (
  input  wire logic [pcdc_pkg::PosW-1:0]          cur_i,
  input  wire logic signed [pcdc_pkg::DeltaW-1:0] delta_i,
  input  wire logic [pcdc_pkg::PosW-1:0]          lo_i,
  input  wire logic [pcdc_pkg::BoundW-1:0]        hi_excl_i,
  output logic      [pcdc_pkg::PosW-1:0]          pos_o
);
  import pcdc_pkg::*;

  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   lo_s;
  logic signed [SumW-1:0]   hi_s;
  logic signed [SumW-1:0]   after_lo;
  logic        [PosW-1:0]   hi_m1;
  logic        [PosW-1:0]   hi;

  assign sum  = $signed({{(SumW-PosW){1'b0}}, cur_i})
              + $signed({{(SumW-DeltaW){delta_i[DeltaW-1]}}, delta_i});
  assign hi_m1 = PosW'(hi_excl_i - BoundW'(1));

  // Inclusive upper limit: zero bound acts as zero, saturate at the screen max.
  always_comb begin
    priority if (hi_excl_i == '0) begin
      hi = '0;
    end else if (hi_excl_i > BoundTop) begin
      hi = PosMax;
    end else begin
      hi = hi_m1;
    end
  end

  assign lo_s     = $signed({{(SumW-PosW){1'b0}}, lo_i});
  assign hi_s     = $signed({{(SumW-PosW){1'b0}}, hi});
  // Lower bound first, upper bound wins when the two cross.
  assign after_lo = (sum < lo_s) ? lo_s : sum;
  assign pos_o    = (after_lo > hi_s) ? hi : after_lo[PosW-1:0];

endmodule : pcdc_clamp

`default_nettype wire

// ===== hdl/pointer_clamp_double_click.sv =====
// ---------------------------------------------------------------------------
// pointer_clamp_double_click: relative pointer tracker with double click
// Accumulate signed deltas into a position clamped to the screen rectangle
// and flag a double click on a press edge that repeats the last press.
// ---------------------------------------------------------------------------
//
//  Channel  | Direction | Beat contents (lowest bits first)
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | button_bits[3:0], delta_x[9:0], delta_y[9:0],
//           |           | time_ms[31:0]
//  m_axis   | out       | pos_x[11:0], pos_y[11:0], button_state[4:0], pad
//  cfg      | in        | write enable, register index, write data
//
// One beat per cycle while m_axis is not stalled. A beat lands in the input
// register, and the clamp and click logic runs between that register and the
// result register, so the result beat is presented once the beat moves into
// the result register, and it stays there until m_axis takes it.
// The tracker state advances when a beat moves into the result register,
// strictly in arrival order. A stall on m_axis holds both registers; the
// input side keeps taking beats while the input register is free.
// Reset clears the position, button history and click stamp, and loads the
// configuration defaults (640 x 480 screen, 400 ms window, limit 10).
// ---------------------------------------------------------------------------
`default_nettype none

module pointer_clamp_double_click (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input stream: button_bits, delta_x, delta_y, time_ms
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [pcdc_pkg::InDataW-1:0]     s_axis_tdata,
  // Output stream: pos_x, pos_y, button_state, zero pad
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [pcdc_pkg::OutDataW-1:0]    m_axis_tdata,
  // Configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [pcdc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  wire logic [pcdc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import pcdc_pkg::*;

  // Configuration registers
  logic [PosW-1:0]   left_q, top_q;
  logic [BoundW-1:0] right_q, bottom_q;
  logic [WinW-1:0]   window_q;
  logic [LimW-1:0]   move_q;

  // Input register
  logic                     in_vld_q;
  logic [BtnW-1:0]          in_btn_q;
  logic signed [DeltaW-1:0] in_dx_q, in_dy_q;
  logic [TimeW-1:0]         in_time_q;

  // Tracker state
  logic [PosW-1:0]  cur_x_q, cur_y_q;
  logic [BtnW-1:0]  prev_btn_q, click_btn_q;
  logic [TimeW-1:0] click_time_q;

  // Result register
  logic              out_vld_q;
  logic [PosW-1:0]   out_x_q, out_y_q;
  logic [StateW-1:0] out_state_q;

  logic              advance, in_take;
  logic [PosW-1:0]   x_d, y_d;
  logic              press_edge, dbl;
  logic [TimeW-1:0]  elapsed;
  logic [DeltaW-1:0] mag_x, mag_y;

  // Move the input beat forward whenever the result register is free or drained.
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= LeftRst;
      top_q    <= TopRst;
      right_q  <= RightRst;
      bottom_q <= BottomRst;
      window_q <= WindowRst;
      move_q   <= MoveRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegLeft:   left_q   <= cfg_wdata_i[PosW-1:0];
        RegTop:    top_q    <= cfg_wdata_i[PosW-1:0];
        RegRight:  right_q  <= cfg_wdata_i[BoundW-1:0];
        RegBottom: bottom_q <= cfg_wdata_i[BoundW-1:0];
        RegWindow: window_q <= cfg_wdata_i[WinW-1:0];
        RegMove:   move_q   <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: valid under reset, payload plain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_btn_q  <= s_axis_tdata[3:0];
      in_dx_q   <= $signed(s_axis_tdata[13:4]);
      in_dy_q   <= $signed(s_axis_tdata[23:14]);
      in_time_q <= s_axis_tdata[55:24];
    end
  end

  // Position update, one clamp per axis.
  pcdc_clamp u_clamp_x (
    .cur_i     (cur_x_q),
    .delta_i   (in_dx_q),
    .lo_i      (left_q),
    .hi_excl_i (right_q),
    .pos_o     (x_d)
  );

  pcdc_clamp u_clamp_y (
    .cur_i     (cur_y_q),
    .delta_i   (in_dy_q),
    .lo_i      (top_q),
    .hi_excl_i (bottom_q),
    .pos_o     (y_d)
  );

  // Double click: same buttons on a fresh press, inside the window, little motion.
  assign press_edge = (in_btn_q != '0) && (prev_btn_q == '0);
  assign elapsed    = in_time_q - click_time_q;
  assign mag_x      = in_dx_q[DeltaW-1] ? DeltaW'(-in_dx_q) : in_dx_q;
  assign mag_y      = in_dy_q[DeltaW-1] ? DeltaW'(-in_dy_q) : in_dy_q;
  assign dbl        = press_edge && (in_btn_q == click_btn_q)
                   && (elapsed < {{(TimeW-WinW){1'b0}}, window_q})
                   && (mag_x < {1'b0, move_q}) && (mag_y < {1'b0, move_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      prev_btn_q   <= '0;
      click_btn_q  <= '0;
      click_time_q <= '0;
    end else if (advance) begin
      cur_x_q    <= x_d;
      cur_y_q    <= y_d;
      prev_btn_q <= in_btn_q;
      // Stamp only on a press edge; releases and held buttons leave it.
      if (press_edge) begin
        click_btn_q  <= in_btn_q;
        click_time_q <= in_time_q;
      end
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_x_q     <= x_d;
      out_y_q     <= y_d;
      out_state_q <= {dbl, in_btn_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW-2*PosW-StateW){1'b0}}, out_state_q, out_y_q, out_x_q};

endmodule : pointer_clamp_double_click

`default_nettype wire
